FILE: hdl/mlru_pkg.sv
package mlru_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam int PAGE_W = 16;
  localparam int FIDX_W = 3;
  localparam int CNT_W  = 16;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef struct packed {
    logic start;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } sts_t;

endpackage

FILE: hdl/matrix_lru_page_replacement.sv
// Matrix LRU page replacement.
// Input channel in_valid/in_ready carries one page reference per transfer.
// Output channel out_valid/out_ready carries one result per reference: hit
// flag, frame used, evicted page if any, and the saturating miss count.
// cfg_wr_en/cfg_wr_data write frames_in_use; write it only while idle.
// After the input transfer the block scans the active frames one per cycle,
// checking each tag for a hit and each age row for the least value, then
// updates the tags and the age matrix and loads the result register. A new
// reference is taken only after that update.
// The result register holds its value while out_ready is low; the next
// reference is still accepted and scanned, but its update waits until the
// previous result has been transferred.
// Reset clears the frame valid bits, the age matrix and the miss count, and
// sets frames_in_use to eight. The block is ready in the first cycle after.
module matrix_lru_page_replacement import mlru_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PAGE_W-1:0] page_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              hit,
  output logic [FIDX_W-1:0] frame_index,
  output logic              evicted_valid,
  output logic [PAGE_W-1:0] evicted_page,
  output logic [CNT_W-1:0]  miss_total
);

  cmd_t cmd;
  sts_t sts;

  mlru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mlru_dp #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .page_number   (page_number),
    .cmd           (cmd),
    .sts           (sts),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .miss_total    (miss_total)
  );

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten before transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted again while a reference is in work");

  a_valid_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result raised without an update");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit reported together with an eviction");

endmodule

FILE: hdl/mlru_ctrl.sv
module mlru_ctrl import mlru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // The result register must be free or emptying before we overwrite it.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: hdl/mlru_dp.sv
module mlru_dp import mlru_pkg::*; #(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic [PAGE_W-1:0] page_number,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              hit,
  output logic [FIDX_W-1:0] frame_index,
  output logic              evicted_valid,
  output logic [PAGE_W-1:0] evicted_page,
  output logic [CNT_W-1:0]  miss_total
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam int NW    = $clog2(FRAMES + 1);

  logic [CFG_W-1:0]     frames_in_use;
  logic [PAGE_BITS-1:0] tags [FRAMES];
  logic [FRAMES-1:0]    valid;
  logic [FRAMES-1:0]    rows [FRAMES];
  logic [CNT_W-1:0]     miss_cnt;

  logic [PAGE_BITS-1:0] page;
  logic [IDX_W-1:0]     scan_idx;
  logic                 hit_found;
  logic [IDX_W-1:0]     hit_idx;
  logic [FRAMES-1:0]    best_w;
  logic [IDX_W-1:0]     best_idx;
  logic                 best_valid;
  logic [PAGE_BITS-1:0] best_tag;

  logic [NW-1:0]        n_active;
  logic [FRAMES-1:0]    nmask;
  logic [FRAMES-1:0]    row_masked;
  logic [FRAMES-1:0]    weight;
  logic                 match;
  logic [IDX_W-1:0]     sel;
  logic [CNT_W-1:0]     miss_cnt_next;

  always_comb begin
    if (frames_in_use == '0) begin
      n_active = NW'(1);
    end else if (int'(frames_in_use) > FRAMES) begin
      n_active = NW'(FRAMES);
    end else begin
      n_active = NW'(frames_in_use);
    end
  end

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      nmask[i] = (i < int'(n_active));
    end
  end

  // Column 0 is the most significant bit of a row's age, so reverse the bits.
  always_comb begin
    row_masked = rows[scan_idx] & nmask;
    for (int i = 0; i < FRAMES; i++) begin
      weight[FRAMES-1-i] = row_masked[i];
    end
  end

  assign match = valid[scan_idx] && (tags[scan_idx] == page);
  assign sts.scan_last = ((NW+1)'(scan_idx) == (NW+1)'(n_active) - (NW+1)'(1));
  assign sel = hit_found ? hit_idx : best_idx;
  assign miss_cnt_next = (miss_cnt == '1) ? miss_cnt : miss_cnt + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= CFG_RESET;
      valid         <= '0;
      miss_cnt      <= '0;
      for (int r = 0; r < FRAMES; r++) begin
        rows[r] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
      if (cmd.commit) begin
        for (int r = 0; r < FRAMES; r++) begin
          if (r == int'(sel)) begin
            rows[r] <= nmask & ~(FRAMES'(1) << sel);
          end else if (r < int'(n_active)) begin
            rows[r] <= rows[r] & ~(FRAMES'(1) << sel);
          end
        end
        if (!hit_found) begin
          valid[sel] <= 1'b1;
          miss_cnt   <= miss_cnt_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && !hit_found) begin
      tags[sel] <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      page      <= PAGE_BITS'(page_number);
      scan_idx  <= '0;
      hit_found <= 1'b0;
    end else if (cmd.step) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (match && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= scan_idx;
      end
      // Strict compare keeps the first row of least age.
      if (scan_idx == '0 || weight < best_w) begin
        best_w     <= weight;
        best_idx   <= scan_idx;
        best_valid <= valid[scan_idx];
        best_tag   <= tags[scan_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hit           <= hit_found;
      frame_index   <= FIDX_W'(sel);
      evicted_valid <= !hit_found && best_valid;
      evicted_page  <= (!hit_found && best_valid) ? PAGE_W'(best_tag) : '0;
      miss_total    <= hit_found ? miss_cnt : miss_cnt_next;
    end
  end

endmodule

FILE: test/testbench.sv
module testbench import mlru_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIRECTED_ROWS  = 25;
  localparam int PHASE_ITEMS    = 67;
  localparam logic [CNT_W-1:0] MISS_CEILING = '1;

  typedef struct packed {
    logic              hit;
    logic [FIDX_W-1:0] frame_index;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  miss_total;
  } lru_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [PAGE_W-1:0] value;
    logic              typed;
    lru_result_t       want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PAGE_W-1:0] page_number = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              hit;
  logic [FIDX_W-1:0] frame_index;
  logic              evicted_valid;
  logic [PAGE_W-1:0] evicted_page;
  logic [CNT_W-1:0]  miss_total;

  // Shadow copy of the replacement state.
  logic [PAGE_W-1:0]     slot_page  [FRAMES_DEF];
  logic                  slot_valid [FRAMES_DEF];
  logic [FRAMES_DEF-1:0] age_row    [FRAMES_DEF];
  logic [CNT_W-1:0]      fault_count;
  logic [CFG_W-1:0]      frames_cfg;

  lru_result_t       predicted_lookups [$];
  logic [PAGE_W-1:0] page_pool [16];
  bit                idle_on;
  int                mismatches;
  int                stall_left;
  int                quiet_cycles;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b0, 16'h0000, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 16'd1}},
    '{1'b0, 16'hFFFF, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 16'd2}},
    '{1'b0, 16'h0000, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 16'd2}},
    '{1'b0, 16'hFFFF, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 16'd2}},
    '{1'b0, 16'h0001, 1'b0, '0},
    '{1'b0, 16'h0002, 1'b0, '0},
    '{1'b0, 16'h0004, 1'b0, '0},
    '{1'b0, 16'h8000, 1'b0, '0},
    '{1'b0, 16'h5555, 1'b0, '0},
    '{1'b0, 16'hAAAA, 1'b0, '0},
    '{1'b0, 16'h1234, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b1, 16'd1,    1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b1, 16'd0,    1'b0, '0},
    '{1'b0, 16'h0F0F, 1'b0, '0},
    '{1'b1, 16'd15,   1'b0, '0},
    '{1'b0, 16'hFFFF, 1'b0, '0},
    '{1'b0, 16'h0002, 1'b0, '0},
    '{1'b1, 16'd2,    1'b0, '0},
    '{1'b0, 16'h00F0, 1'b0, '0},
    '{1'b0, 16'h0001, 1'b0, '0},
    '{1'b1, 16'd8,    1'b0, '0},
    '{1'b0, 16'hF00F, 1'b0, '0}
  };

  int cfg_plan [12] = '{3, 8, 1, 15, 2, 0, 5, 12, 7, 4, 6, 9};

  matrix_lru_page_replacement i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .miss_total    (miss_total)
  );

  always #5 clk = ~clk;

  // A register value of zero still manages one frame; values above the
  // frame count are clipped.
  function automatic int active_frames();
    if (frames_cfg == '0) return 1;
    if (frames_cfg > FRAMES_DEF) return FRAMES_DEF;
    return int'(frames_cfg);
  endfunction

  function automatic lru_result_t lru_reference(input logic [PAGE_W-1:0] pg);
    lru_result_t r;
    int n;
    int f;
    int w;
    int best_w;
    bit found;
    n = active_frames();
    r = '0;
    f = 0;
    best_w = 0;
    found = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (!found && slot_valid[k] && slot_page[k] == pg) begin
        found = 1'b1;
        f = k;
      end
    end
    if (!found) begin
      // Column 0 weighs most; the first row of least weight is the victim.
      for (int k = 0; k < n; k++) begin
        w = 0;
        for (int j = 0; j < n; j++) w = (w << 1) | int'(age_row[k][j]);
        if (k == 0 || w < best_w) begin
          best_w = w;
          f = k;
        end
      end
      if (slot_valid[f]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = slot_page[f];
      end
      slot_page[f]  = pg;
      slot_valid[f] = 1'b1;
      if (fault_count != MISS_CEILING) fault_count++;
    end
    age_row[f] = '0;
    for (int k = 0; k < n; k++) age_row[f][k] = 1'b1;
    for (int k = 0; k < n; k++) age_row[k][f] = 1'b0;
    r.hit         = found;
    r.frame_index = FIDX_W'(f);
    r.miss_total  = fault_count;
    return r;
  endfunction

  function automatic logic [PAGE_W-1:0] pick_page();
    int span;
    span = active_frames() + 3;
    if ($urandom_range(0, 4) == 0) return PAGE_W'($urandom);
    return page_pool[$urandom_range(0, span)];
  endfunction

  task automatic send_page(input logic [PAGE_W-1:0] pg, input logic typed,
                           input lru_result_t want);
    lru_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = lru_reference(pg);
    predicted_lookups.push_back(typed ? want : predicted);
  endtask

  // The frame count may only change once every outstanding lookup is back.
  task automatic write_frames(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (predicted_lookups.size() != 0) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    frames_cfg  = value;
  endtask

  always @(posedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 19);
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    lru_result_t got;
    lru_result_t want;
    got = {hit, frame_index, evicted_valid, evicted_page, miss_total};
    if (!rst && out_valid && out_ready) begin
      if (predicted_lookups.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result transfer with nothing outstanding, frame=%0d",
                   $time, frame_index);
      end else begin
        want = predicted_lookups.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected hit=%0b frame=%0d evicted=%0b/%h misses=%0d, ",
                     $time, want.hit, want.frame_index, want.evicted_valid,
                     want.evicted_page, want.miss_total,
                     "got hit=%0b frame=%0d evicted=%0b/%h misses=%0d",
                     got.hit, got.frame_index, got.evicted_valid,
                     got.evicted_page, got.miss_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < FRAMES_DEF; i++) begin
      slot_page[i]  = '0;
      slot_valid[i] = 1'b0;
      age_row[i]    = '0;
    end
    fault_count = '0;
    frames_cfg  = CFG_RESET;
    foreach (page_pool[i]) page_pool[i] = PAGE_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    idle_on = 1'b1;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_frames(directed_rows[i].value[CFG_W-1:0]);
      else
        send_page(directed_rows[i].value, directed_rows[i].typed, directed_rows[i].want);
    end

    // Tags left behind by one frame count come back into play under the next.
    foreach (cfg_plan[p]) begin
      write_frames(CFG_W'(cfg_plan[p]));
      idle_on = ($urandom_range(0, 3) != 0);
      page_pool[$urandom_range(2, 15)] = PAGE_W'($urandom);
      repeat (PHASE_ITEMS) send_page(pick_page(), 1'b0, '0);
    end

    // From here on both sides run flat out. With a single frame nearly every
    // reference faults.
    idle_on = 1'b0;
    write_frames(CFG_W'(1));
    repeat (20) send_page(PAGE_W'($urandom), 1'b0, '0);
    write_frames(CFG_W'(8));
    repeat (60) send_page(pick_page(), 1'b0, '0);
    write_frames(CFG_W'(4));
    repeat (40) send_page(pick_page(), 1'b0, '0);

    in_valid <= 1'b0;
    while (predicted_lookups.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && predicted_lookups.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/mlru_pkg.sv
hdl/mlru_ctrl.sv
hdl/mlru_dp.sv
hdl/matrix_lru_page_replacement.sv
test/testbench.sv
